// ===== src/ptb_pkg.sv =====
package ptb_pkg;

   // Text and alphabet sizes.
   localparam int MAX_TEXT   = 1024;
   localparam int ALPHABET   = 26;
   localparam int NODE_SLOTS = MAX_TEXT + 3;
   localparam int CHILD_DEPTH = NODE_SLOTS * ALPHABET;

   // Widths that follow from the sizes above.
   localparam int SYM_W    = 5;
   localparam int POS_W    = $clog2(MAX_TEXT + 1);
   localparam int LEN_W    = POS_W;
   localparam int NODE_W   = $clog2(NODE_SLOTS);
   localparam int TEXT_AW  = $clog2(MAX_TEXT);
   localparam int CHILD_AW = $clog2(CHILD_DEPTH);

   // Root nodes and their fixed lengths.
   localparam logic [NODE_W-1:0] NO_NODE   = NODE_W'(0);
   localparam logic [NODE_W-1:0] EVEN_ROOT = NODE_W'(1);
   localparam logic [NODE_W-1:0] ODD_ROOT  = NODE_W'(2);
   localparam logic signed [LEN_W:0] EVEN_LEN = (LEN_W+1)'(0);
   localparam logic signed [LEN_W:0] ODD_LEN  = {(LEN_W+1){1'b1}};
   localparam logic signed [LEN_W:0] LEN_STEP = (LEN_W+1)'(2);

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_NODE_RD,
      S_TEXT_RD,
      S_CMP,
      S_CHILD_RD,
      S_CHILD_CHK,
      S_LINK_RD,
      S_LINK_CHK,
      S_EMIT
   } ptb_state_type;

   // One word of the node and text store.
   typedef struct packed {
      logic [SYM_W-1:0]  sym;
      logic [LEN_W-1:0]  len;
      logic [NODE_W-1:0] link;
   } ptb_node_word_type;

   // Access request to the node and text store.
   typedef struct packed {
      logic [NODE_W-1:0] rd_addr;
      logic              sym_we;
      logic [NODE_W-1:0] sym_addr;
      logic [SYM_W-1:0]  sym;
      logic              node_we;
      logic [NODE_W-1:0] node_addr;
      logic [LEN_W-1:0]  len;
      logic [NODE_W-1:0] link;
   } ptb_node_req_type;

   // Access request to the child table.
   typedef struct packed {
      logic [CHILD_AW-1:0] addr;
      logic                we;
      logic [NODE_W-1:0]   wdata;
   } ptb_child_req_type;

   // Status of the child table.
   typedef struct packed {
      logic              clearing;
      logic [NODE_W-1:0] rd_data;
   } ptb_child_stat_type;

endpackage

// ===== src/ptb_if.sv =====
// Request channel: one text symbol per request.
interface ptb_req_if;
   logic                      valid;
   logic                      ready;
   logic [ptb_pkg::SYM_W-1:0] symbol;

   modport source (output valid, output symbol, input ready);
   modport sink (input valid, input symbol, output ready);
endinterface

// Result channel: one result per request.
interface ptb_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] suffix_length;
   logic [10:0] suffix_node;
   logic        new_palindrome;
   logic [10:0] distinct_count;
   logic        overflow;

   modport source (output valid, output suffix_length, output suffix_node,
                   output new_palindrome, output distinct_count, output overflow,
                   input ready);
   modport sink (input valid, input suffix_length, input suffix_node,
                 input new_palindrome, input distinct_count, input overflow,
                 output ready);
endinterface

// ===== src/ptb_node_store.sv =====
// Node and text store: one synchronous memory. Each entry holds a text symbol
// (entries below the text size) and a node's length and suffix link.
module ptb_node_store (
   input  logic                         clock,
   input  ptb_pkg::ptb_node_req_type    node_req,
   output ptb_pkg::ptb_node_word_type   node_rd
);

   ptb_pkg::ptb_node_word_type node_mem [ptb_pkg::NODE_SLOTS];
   ptb_pkg::ptb_node_word_type rd_ff;

   // The symbol and node fields are written separately, never in the same cycle.
   always_ff @(posedge clock) begin
      if (node_req.sym_we) begin
         node_mem[node_req.sym_addr].sym <= node_req.sym;
      end
      if (node_req.node_we) begin
         node_mem[node_req.node_addr].len  <= node_req.len;
         node_mem[node_req.node_addr].link <= node_req.link;
      end
      rd_ff <= node_mem[node_req.rd_addr];
   end

   assign node_rd = rd_ff;

endmodule

// ===== src/ptb_child_store.sv =====
// Child table: one synchronous memory indexed by node times alphabet plus
// symbol. After reset a sweep writes zero to every entry, one per cycle.
module ptb_child_store (
   input  logic                         clock,
   input  logic                         reset,
   input  ptb_pkg::ptb_child_req_type   child_req,
   output ptb_pkg::ptb_child_stat_type  child_stat
);

   logic [ptb_pkg::NODE_W-1:0]   child_mem [ptb_pkg::CHILD_DEPTH];
   logic [ptb_pkg::NODE_W-1:0]   rd_ff;
   logic                         clearing_ff;
   logic                         clearing_in;
   logic [ptb_pkg::CHILD_AW-1:0] sweep_ff;
   logic [ptb_pkg::CHILD_AW-1:0] sweep_in;
   logic [ptb_pkg::CHILD_AW-1:0] wr_addr;
   logic [ptb_pkg::NODE_W-1:0]   wr_data;
   logic                         wr_en;

   // Sweep counter for the clearing pass.
   always_comb begin
      sweep_in    = sweep_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         sweep_in = sweep_ff + ptb_pkg::CHILD_AW'(1);
         if (sweep_ff == ptb_pkg::CHILD_AW'(ptb_pkg::CHILD_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         sweep_ff    <= '0;
      end else begin
         clearing_ff <= clearing_in;
         sweep_ff    <= sweep_in;
      end
   end

   // The sweep owns the write port while it runs.
   assign wr_en   = clearing_ff | child_req.we;
   assign wr_addr = clearing_ff ? sweep_ff : child_req.addr;
   assign wr_data = clearing_ff ? ptb_pkg::NO_NODE : child_req.wdata;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         child_mem[wr_addr] <= wr_data;
      end
      rd_ff <= child_mem[child_req.addr];
   end

   assign child_stat.clearing = clearing_ff;
   assign child_stat.rd_data  = rd_ff;

endmodule

// ===== src/palindromic_tree_builder.sv =====
// Channel   Direction  Carries
// req_bus   in         symbol
// rsp_bus   out        suffix_length, suffix_node, new_palindrome,
//                      distinct_count, overflow
//
// A walk step has a node read, a text read and a compare, or stops before the
// compare at the odd root or where the palindrome reaches back before the text.
// The child lookup reads and checks the child table, a new node adds a second
// walk and a link lookup, and an ignored symbol goes straight from accept to result.
// Reset starts a clear of the child table; no request is taken until it ends.
// A request is taken while a result waits; the next result waits for it.
module palindromic_tree_builder (
   input  logic           clock,
   input  logic           reset,
   ptb_req_if.sink        req_bus,
   ptb_rsp_if.source      rsp_bus
);

   ptb_pkg::ptb_node_req_type   node_req;
   ptb_pkg::ptb_node_word_type  node_rd;
   ptb_pkg::ptb_child_req_type  child_req;
   ptb_pkg::ptb_child_stat_type child_stat;

   ptb_pkg::ptb_state_type state_ff, state_in;

   logic                                phase_ff, phase_in;
   logic [ptb_pkg::SYM_W-1:0]           sym_ff, sym_in;
   logic [ptb_pkg::POS_W-1:0]           pos_ff, pos_in;
   logic [ptb_pkg::NODE_W-1:0]          walk_ff, walk_in;
   logic signed [ptb_pkg::LEN_W:0]      cur_len_ff, cur_len_in;
   logic [ptb_pkg::NODE_W-1:0]          cur_link_ff, cur_link_in;
   logic [ptb_pkg::NODE_W-1:0]          found_ff, found_in;
   logic signed [ptb_pkg::LEN_W:0]      found_len_ff, found_len_in;
   logic [ptb_pkg::NODE_W-1:0]          found_link_ff, found_link_in;
   logic [ptb_pkg::LEN_W-1:0]           new_len_ff, new_len_in;
   logic [ptb_pkg::NODE_W-1:0]          last_node_ff, last_node_in;
   logic [ptb_pkg::LEN_W-1:0]           last_len_ff, last_len_in;
   logic [ptb_pkg::NODE_W-1:0]          node_total_ff, node_total_in;
   logic                                made_ff, made_in;
   logic                                ovf_ff, ovf_in;

   logic                                rsp_valid_ff;
   logic [10:0]                         rsp_len_ff;
   logic [10:0]                         rsp_node_ff;
   logic                                rsp_made_ff;
   logic [10:0]                         rsp_count_ff;
   logic                                rsp_ovf_ff;
   logic                                rsp_load;

   logic                                walk_hit;
   logic signed [ptb_pkg::LEN_W:0]      hit_len;
   logic [ptb_pkg::NODE_W-1:0]          hit_link;
   logic signed [ptb_pkg::LEN_W:0]      eff_len;
   logic [ptb_pkg::NODE_W-1:0]          eff_link;
   logic [ptb_pkg::POS_W:0]             q_wide;
   logic [ptb_pkg::NODE_W-1:0]          child_sel;
   logic [ptb_pkg::NODE_W-1:0]          new_node;
   logic [ptb_pkg::NODE_W-1:0]          new_link;

   ptb_node_store u_node_store (
      .clock    (clock),
      .node_req (node_req),
      .node_rd  (node_rd)
   );

   ptb_child_store u_child_store (
      .clock      (clock),
      .reset      (reset),
      .child_req  (child_req),
      .child_stat (child_stat)
   );

   // Values of the node under the walk; the even root is fixed here and not read.
   always_comb begin
      if (walk_ff == ptb_pkg::EVEN_ROOT) begin
         eff_len  = ptb_pkg::EVEN_LEN;
         eff_link = ptb_pkg::ODD_ROOT;
      end else begin
         eff_len  = {1'b0, node_rd.len};
         eff_link = node_rd.link;
      end
   end

   // Text position just before the palindrome; negative means no match.
   assign q_wide = {1'b0, pos_ff} - {1'b0, eff_len[ptb_pkg::LEN_W-1:0]}
                   - (ptb_pkg::POS_W+1)'(1);

   assign new_node = node_total_ff + ptb_pkg::NODE_W'(1);
   assign new_link = (child_stat.rd_data != ptb_pkg::NO_NODE) ?
                     child_stat.rd_data : ptb_pkg::EVEN_ROOT;

   // Child table address: the lookup node comes from the walk or the found node.
   assign child_sel = (state_ff == ptb_pkg::S_LINK_RD) ? walk_ff : found_ff;
   assign child_req.addr = ptb_pkg::CHILD_AW'(child_sel)
                           * ptb_pkg::CHILD_AW'(ptb_pkg::ALPHABET)
                           + ptb_pkg::CHILD_AW'(sym_ff);
   assign child_req.we    = (state_ff == ptb_pkg::S_LINK_CHK);
   assign child_req.wdata = new_node;

   // Sequencer: next state, store accesses and updates of the tree state.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      sym_in        = sym_ff;
      pos_in        = pos_ff;
      walk_in       = walk_ff;
      cur_len_in    = cur_len_ff;
      cur_link_in   = cur_link_ff;
      found_in      = found_ff;
      found_len_in  = found_len_ff;
      found_link_in = found_link_ff;
      new_len_in    = new_len_ff;
      last_node_in  = last_node_ff;
      last_len_in   = last_len_ff;
      node_total_in = node_total_ff;
      made_in       = made_ff;
      ovf_in        = ovf_ff;
      rsp_load      = 1'b0;
      walk_hit      = 1'b0;
      hit_len       = cur_len_ff;
      hit_link      = cur_link_ff;

      node_req.rd_addr   = walk_ff;
      node_req.sym_we    = 1'b0;
      node_req.sym_addr  = ptb_pkg::NODE_W'(pos_ff[ptb_pkg::TEXT_AW-1:0]);
      node_req.sym       = req_bus.symbol;
      node_req.node_we   = 1'b0;
      node_req.node_addr = new_node;
      node_req.len       = new_len_ff;
      node_req.link      = new_link;

      req_bus.ready = (state_ff == ptb_pkg::S_IDLE) && !child_stat.clearing;

      case (state_ff)
         ptb_pkg::S_IDLE: begin
            if (req_bus.valid && req_bus.ready) begin
               sym_in  = req_bus.symbol;
               made_in = 1'b0;
               ovf_in  = 1'b0;
               if (pos_ff == ptb_pkg::POS_W'(ptb_pkg::MAX_TEXT)) begin
                  ovf_in   = 1'b1;
                  state_in = ptb_pkg::S_EMIT;
               end else if (req_bus.symbol >= ptb_pkg::SYM_W'(ptb_pkg::ALPHABET)) begin
                  state_in = ptb_pkg::S_EMIT;
               end else begin
                  node_req.sym_we = 1'b1;
                  phase_in        = 1'b0;
                  walk_in         = last_node_ff;
                  state_in        = ptb_pkg::S_NODE_RD;
               end
            end
         end
         ptb_pkg::S_NODE_RD: begin
            state_in = ptb_pkg::S_TEXT_RD;
         end
         ptb_pkg::S_TEXT_RD: begin
            // The odd root always matches; else fetch the text symbol, if any.
            cur_len_in  = eff_len;
            cur_link_in = eff_link;
            if (walk_ff == ptb_pkg::ODD_ROOT) begin
               walk_hit = 1'b1;
               hit_len  = ptb_pkg::ODD_LEN;
               hit_link = ptb_pkg::ODD_ROOT;
            end else if (q_wide[ptb_pkg::POS_W]) begin
               walk_in  = eff_link;
               state_in = ptb_pkg::S_NODE_RD;
            end else begin
               node_req.rd_addr = ptb_pkg::NODE_W'(q_wide[ptb_pkg::TEXT_AW-1:0]);
               state_in         = ptb_pkg::S_CMP;
            end
         end
         ptb_pkg::S_CMP: begin
            if (node_rd.sym == sym_ff) begin
               walk_hit = 1'b1;
            end else begin
               walk_in  = cur_link_ff;
               state_in = ptb_pkg::S_NODE_RD;
            end
         end
         ptb_pkg::S_CHILD_RD: begin
            state_in = ptb_pkg::S_CHILD_CHK;
         end
         ptb_pkg::S_CHILD_CHK: begin
            if (child_stat.rd_data != ptb_pkg::NO_NODE) begin
               last_node_in = child_stat.rd_data;
               last_len_in  = ptb_pkg::LEN_W'(found_len_ff + ptb_pkg::LEN_STEP);
               pos_in       = pos_ff + ptb_pkg::POS_W'(1);
               state_in     = ptb_pkg::S_EMIT;
            end else begin
               // New node: its suffix link comes from a second walk.
               new_len_in = ptb_pkg::LEN_W'(found_len_ff + ptb_pkg::LEN_STEP);
               phase_in   = 1'b1;
               walk_in    = found_link_ff;
               state_in   = ptb_pkg::S_NODE_RD;
            end
         end
         ptb_pkg::S_LINK_RD: begin
            state_in = ptb_pkg::S_LINK_CHK;
         end
         ptb_pkg::S_LINK_CHK: begin
            node_req.node_we = 1'b1;
            node_total_in    = new_node;
            last_node_in     = new_node;
            last_len_in      = new_len_ff;
            made_in          = 1'b1;
            pos_in           = pos_ff + ptb_pkg::POS_W'(1);
            state_in         = ptb_pkg::S_EMIT;
         end
         ptb_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ptb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ptb_pkg::S_IDLE;
         end
      endcase

      // End of a walk: the first finds the parent, the second the link source.
      if (walk_hit) begin
         if (!phase_ff) begin
            found_in      = walk_ff;
            found_len_in  = hit_len;
            found_link_in = hit_link;
            state_in      = ptb_pkg::S_CHILD_RD;
         end else begin
            state_in = ptb_pkg::S_LINK_RD;
         end
      end
   end

   // Control and tree state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptb_pkg::S_IDLE;
         pos_ff        <= '0;
         last_node_ff  <= ptb_pkg::ODD_ROOT;
         last_len_ff   <= '0;
         node_total_ff <= ptb_pkg::ODD_ROOT;
         phase_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         last_node_ff  <= last_node_in;
         last_len_ff   <= last_len_in;
         node_total_ff <= node_total_in;
         phase_ff      <= phase_in;
      end
   end

   // Working registers of the walks.
   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      walk_ff       <= walk_in;
      cur_len_ff    <= cur_len_in;
      cur_link_ff   <= cur_link_in;
      found_ff      <= found_in;
      found_len_ff  <= found_len_in;
      found_link_ff <= found_link_in;
      new_len_ff    <= new_len_in;
      made_ff       <= made_in;
      ovf_ff        <= ovf_in;
   end

   // Output register for the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_len_ff   <= 11'(last_len_ff);
         rsp_node_ff  <= 11'(last_node_ff);
         rsp_made_ff  <= made_ff;
         rsp_count_ff <= 11'(node_total_ff - ptb_pkg::ODD_ROOT);
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.suffix_length  = rsp_len_ff;
   assign rsp_bus.suffix_node    = rsp_node_ff;
   assign rsp_bus.new_palindrome = rsp_made_ff;
   assign rsp_bus.distinct_count = rsp_count_ff;
   assign rsp_bus.overflow       = rsp_ovf_ff;

`ifndef ASSERT_OFF
   // No request is taken while the child table is being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      child_stat.clearing |-> !req_bus.ready)
      else $error("request accepted during child table clear");

   // The last node is always one that exists.
   a_last_node_exists: assert property (@(posedge clock) disable iff (reset)
      last_node_ff <= node_total_ff)
      else $error("last node beyond node count");

   // Creating a node adds exactly one to the node count.
   a_node_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptb_pkg::S_LINK_CHK |=>
         node_total_ff == $past(node_total_ff) + ptb_pkg::NODE_W'(1))
      else $error("node count did not step by one");

   // The text position never passes the text size.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= ptb_pkg::POS_W'(ptb_pkg::MAX_TEXT))
      else $error("text position beyond text size");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;

   localparam int LIMIT_CYCLES  = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HALF_TEXT     = ptb_pkg::MAX_TEXT / 2;
   localparam int SYM_MAX       = (1 << ptb_pkg::SYM_W) - 1;

   // One result as the block reports it.
   typedef struct packed {
      logic [ptb_pkg::LEN_W-1:0]  suffix_length;
      logic [ptb_pkg::NODE_W-1:0] suffix_node;
      logic                       new_palindrome;
      logic [ptb_pkg::LEN_W-1:0]  distinct_count;
      logic                       overflow;
   } suffix_report_type;

   // Shapes of random text pieces.
   typedef enum int {
      CHUNK_RUN,
      CHUNK_MIRROR,
      CHUNK_PAIRS,
      CHUNK_ANY,
      CHUNK_NOISE
   } chunk_kind_type;

   logic clock;
   logic reset;

   ptb_req_if req_bus ();
   ptb_rsp_if rsp_bus ();

   palindromic_tree_builder DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow copy of the text and the tree.
   logic [ptb_pkg::SYM_W-1:0] text_mem [ptb_pkg::MAX_TEXT];
   int                        node_len [ptb_pkg::NODE_SLOTS];
   int                        link_of [ptb_pkg::NODE_SLOTS];
   int                        child_of [ptb_pkg::CHILD_DEPTH];
   int                        last_nd;
   int                        node_cnt;
   int                        text_pos;

   suffix_report_type expected_reports [$];
   int                send_idle_pct;
   int                recv_idle_pct;
   int                failures = 0;
   int                cycle_count = 0;

   // Empty tree: the two roots, both linked to the odd root.
   function automatic void clear_tree();
      foreach (node_len[i]) begin
         node_len[i] = 0;
         link_of[i]  = 0;
      end
      foreach (child_of[i]) child_of[i] = 0;
      foreach (text_mem[i]) text_mem[i] = '0;
      node_len[ptb_pkg::EVEN_ROOT] = 0;
      node_len[ptb_pkg::ODD_ROOT]  = -1;
      link_of[ptb_pkg::EVEN_ROOT]  = int'(ptb_pkg::ODD_ROOT);
      link_of[ptb_pkg::ODD_ROOT]   = int'(ptb_pkg::ODD_ROOT);
      last_nd  = int'(ptb_pkg::ODD_ROOT);
      node_cnt = 2;
      text_pos = 0;
   endfunction

   // True when the symbol just before palindrome v, ending at pos, equals c.
   // A position before the start of the text never matches.
   function automatic bit fits_before(int v, int pos, int c);
      int q;
      q = pos - node_len[v] - 1;
      if (q < 0 || q > pos) return 1'b0;
      return int'(text_mem[q]) == c;
   endfunction

   function automatic int walk_links(int v, int pos, int c);
      int u;
      u = v;
      while (!fits_before(u, pos, c)) u = link_of[u];
      return u;
   endfunction

   // The odd root reports a length of zero.
   function automatic suffix_report_type report_node(int nd, bit made, bit ovf);
      suffix_report_type r;
      r.suffix_length  = (node_len[nd] > 0) ? ptb_pkg::LEN_W'(node_len[nd]) : '0;
      r.suffix_node    = ptb_pkg::NODE_W'(nd);
      r.new_palindrome = made;
      r.distinct_count = ptb_pkg::LEN_W'(node_cnt - 2);
      r.overflow       = ovf;
      return r;
   endfunction

   // Appends one symbol to the shadow tree and returns the expected result.
   function automatic suffix_report_type extend_tree(logic [ptb_pkg::SYM_W-1:0] sym);
      int c;
      int pos;
      int v;
      int n;
      int t;
      int lk;
      bit made;
      c    = int'(sym);
      pos  = text_pos;
      made = 1'b0;
      if (pos >= ptb_pkg::MAX_TEXT) return report_node(last_nd, 1'b0, 1'b1);
      if (c >= ptb_pkg::ALPHABET) return report_node(last_nd, 1'b0, 1'b0);
      text_mem[pos] = sym;
      v = walk_links(last_nd, pos, c);
      if (child_of[v * ptb_pkg::ALPHABET + c] == 0) begin
         n = node_cnt + 1;
         node_len[n] = node_len[v] + 2;
         t  = walk_links(link_of[v], pos, c);
         lk = child_of[t * ptb_pkg::ALPHABET + c];
         link_of[n] = (lk != 0) ? lk : int'(ptb_pkg::EVEN_ROOT);
         child_of[v * ptb_pkg::ALPHABET + c] = n;
         node_cnt = n;
         made = 1'b1;
      end
      last_nd  = child_of[v * ptb_pkg::ALPHABET + c];
      text_pos = pos + 1;
      return report_node(last_nd, made, 1'b0);
   endfunction

   // Offers one request, with random idle cycles first, and records the
   // expected result once the request is taken.
   task automatic send_symbol(input logic [ptb_pkg::SYM_W-1:0] sym);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.symbol <= sym;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_reports.insert(expected_reports.size(), extend_tree(sym));
   endtask

   // Drops valid and waits until every expected result has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   // Ignored symbols at the odd root, bit extremes and short palindromes.
   task automatic test_directed_symbols();
      int picks [$] = '{31, 26, 0, 0, 0, 25, 0, 0, 0, 1, 2, 1, 25, 25, 30,
                        12, 5, 12, 16, 8, 4, 2, 1, 0, 27};
      foreach (picks[i]) send_symbol(ptb_pkg::SYM_W'(picks[i]));
   endtask

   // Structured random text: runs, mirrored pieces, two or three letter
   // alphabets, free text and an occasional out-of-alphabet symbol.
   task automatic test_random_text(input int stop_pos);
      int picks [$];
      int roll;
      int span;
      int base;
      int width;
      int half;
      int k;
      chunk_kind_type kind;
      while (text_pos < stop_pos) begin
         picks.delete();
         roll  = $urandom_range(0, 9);
         span  = $urandom_range(1, 24);
         base  = $urandom_range(0, ptb_pkg::ALPHABET - 1);
         width = $urandom_range(1, 2);
         kind  = roll < 2 ? CHUNK_RUN : roll < 4 ? CHUNK_MIRROR :
                 roll < 7 ? CHUNK_PAIRS : roll < 9 ? CHUNK_ANY : CHUNK_NOISE;
         case (kind)
            CHUNK_RUN: begin
               repeat (span) picks.insert(picks.size(), base);
            end
            CHUNK_MIRROR: begin
               repeat (span / 2 + 1)
                  picks.insert(picks.size(),
                               (base + $urandom_range(0, width)) % ptb_pkg::ALPHABET);
               half = picks.size();
               if ($urandom_range(0, 1) == 1)
                  picks.insert(picks.size(), $urandom_range(0, ptb_pkg::ALPHABET - 1));
               for (k = half - 1; k >= 0; k--) picks.insert(picks.size(), picks[k]);
            end
            CHUNK_PAIRS: begin
               repeat (span)
                  picks.insert(picks.size(),
                               (base + $urandom_range(0, width)) % ptb_pkg::ALPHABET);
            end
            CHUNK_ANY: begin
               repeat (span)
                  picks.insert(picks.size(), $urandom_range(0, ptb_pkg::ALPHABET - 1));
            end
            default: begin
               picks.insert(picks.size(), $urandom_range(ptb_pkg::ALPHABET, SYM_MAX));
            end
         endcase
         foreach (picks[i]) begin
            if (text_pos >= stop_pos) break;
            send_symbol(ptb_pkg::SYM_W'(picks[i]));
         end
      end
   endtask

   // Second half of the text mirrors the first, so the whole store ends as
   // one palindrome of full length.
   task automatic test_mirror_text(input int stop_pos);
      while (text_pos < stop_pos) begin
         if ($urandom_range(0, 49) == 0)
            send_symbol(ptb_pkg::SYM_W'($urandom_range(ptb_pkg::ALPHABET, SYM_MAX)));
         else
            send_symbol(text_mem[ptb_pkg::MAX_TEXT - 1 - text_pos]);
      end
   endtask

   // With the store full every symbol is ignored and flagged.
   task automatic test_store_full();
      send_symbol('0);
      send_symbol(ptb_pkg::SYM_W'(SYM_MAX));
      repeat (100) send_symbol(ptb_pkg::SYM_W'($urandom_range(0, SYM_MAX)));
   endtask

   task automatic check_field(input string label, input logic [10:0] want,
                              input logic [10:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
         failures++;
      end
   endtask

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver stalls at random; ready changes at the falling edge.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Each result taken is compared with the oldest expected result.
   always @(posedge clock) begin : check_results
      suffix_report_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: result with no request waiting: expected none, actual node %0d",
                     $time, rsp_bus.suffix_node);
            failures++;
         end else begin
            want = expected_reports.pop_front();
            check_field("suffix_length", want.suffix_length, rsp_bus.suffix_length);
            check_field("suffix_node", want.suffix_node, rsp_bus.suffix_node);
            check_field("new_palindrome", want.new_palindrome, rsp_bus.new_palindrome);
            check_field("distinct_count", want.distinct_count, rsp_bus.distinct_count);
            check_field("overflow", want.overflow, rsp_bus.overflow);
         end
      end
   end

   // Run limit, which also covers the child table clear after reset.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.symbol = '0;
      send_idle_pct  = 18;
      recv_idle_pct  = 81;
      clear_tree();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Slow receiver.
      test_directed_symbols();
      test_random_text(340);
      hold_until_drained();

      // Slow sender, crossing into the mirrored half.
      send_idle_pct = 81;
      recv_idle_pct = 18;
      test_random_text(HALF_TEXT);
      test_mirror_text(680);
      hold_until_drained();

      // No idling on either side, up to a full store and past it.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_mirror_text(ptb_pkg::MAX_TEXT);
      test_store_full();
      hold_until_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
